### hdl/bra_pkg.sv
`default_nettype none
package bra_pkg;

  // Field widths fixed by the item formats.
  localparam int IDX_W       = 4;
  localparam int ROW_W       = 16;
  localparam int NODE_W      = 5;
  localparam int STORE_DEPTH = 16;

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Register indexes (word address = paddr[2]).
  localparam logic REG_NODE_COUNT = 1'b0;

  localparam logic [NODE_W-1:0] NODE_COUNT_RESET = NODE_W'(16);

  // One classified input item as it travels through the queue.
  typedef struct packed {
    logic [IDX_W-1:0]  row_index;
    logic [ROW_W-1:0]  row_bits;
    logic              last_row;
    logic [NODE_W-1:0] nodes;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic [IDX_W-1:0] out_row;
    logic [ROW_W-1:0] closure_row;
    logic [ROW_W-1:0] reflexive_row;
    logic [ROW_W-1:0] symmetric_row;
    logic [ROW_W-1:0] inverse_row;
    logic [ROW_W-1:0] square_row;
    logic             is_reflexive;
    logic             is_irreflexive;
    logic             is_transitive;
    logic             is_symmetric;
    logic             is_antisymmetric;
    logic             last_result;
  } res_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_PREP,
    ST_CLOSE,
    ST_EMIT
  } eng_state_t;

endpackage
`default_nettype wire

### hdl/bra_front.sv
`default_nettype none
module bra_front #(
  parameter int MAX_NODES = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // Configuration port.
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [bra_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [bra_pkg::PDATA_W-1:0]  pwdata,
  output logic      [bra_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready,
  // Input channel.
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [bra_pkg::IDX_W-1:0]    in_row_index,
  input  wire logic [bra_pkg::ROW_W-1:0]    in_row_bits,
  input  wire logic                         in_last_row,
  // Queue write side.
  input  wire logic                         q_full,
  output logic                              q_push,
  output bra_pkg::cmd_t                     q_cmd
);

  localparam int NW    = bra_pkg::NODE_W;
  localparam int LIMIT = (MAX_NODES < bra_pkg::STORE_DEPTH) ? MAX_NODES
                                                            : bra_pkg::STORE_DEPTH;
  localparam logic [NW-1:0] LIMIT_N = NW'(LIMIT);

  logic [NW-1:0] node_count_r;
  logic [NW-1:0] nodes_clamped;
  logic          reg_hit;

  assign reg_hit = (paddr[2] == bra_pkg::REG_NODE_COUNT);
  assign pready  = 1'b1;

  // Register write on the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= bra_pkg::NODE_COUNT_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      node_count_r <= pwdata[NW-1:0];
    end
  end

  // Register read.
  always_comb begin
    prdata = '0;
    if (psel && !pwrite && reg_hit) begin
      prdata = {{(bra_pkg::PDATA_W-NW){1'b0}}, node_count_r};
    end
  end

  // Bring the element count into the supported range.
  always_comb begin
    nodes_clamped = node_count_r;
    if (node_count_r == '0) begin
      nodes_clamped = NW'(1);
    end else if (node_count_r > LIMIT_N) begin
      nodes_clamped = LIMIT_N;
    end
  end

  // Classify the item and hand it to the queue.
  assign in_ready         = !q_full;
  assign q_push           = in_valid && in_ready;
  assign q_cmd.row_index  = in_row_index;
  assign q_cmd.row_bits   = in_row_bits;
  assign q_cmd.last_row   = in_last_row;
  assign q_cmd.nodes      = nodes_clamped;

endmodule
`default_nettype wire

### hdl/bra_queue.sv
`default_nettype none
module bra_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire bra_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output bra_pkg::cmd_t      pop_cmd,
  output logic               empty
);

  localparam int PW = bra_pkg::QPTR_W;

  bra_pkg::cmd_t  entry_r [bra_pkg::QUEUE_DEPTH];
  logic [PW:0]    wr_ptr_r;
  logic [PW:0]    rd_ptr_r;

  assign empty   = (wr_ptr_r == rd_ptr_r);
  assign full    = (wr_ptr_r[PW] != rd_ptr_r[PW]) &&
                   (wr_ptr_r[PW-1:0] == rd_ptr_r[PW-1:0]);
  assign pop_cmd = entry_r[rd_ptr_r[PW-1:0]];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push && !full) begin
      entry_r[wr_ptr_r[PW-1:0]] <= push_cmd;
    end
  end

  // Pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= wr_ptr_r + (PW+1)'(1);
      end
      if (pop && !empty) begin
        rd_ptr_r <= rd_ptr_r + (PW+1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

### hdl/bra_engine.sv
`default_nettype none
module bra_engine (
  input  wire logic          clk,
  input  wire logic          rst_n,
  // Queue read side.
  input  wire logic          q_empty,
  input  wire bra_pkg::cmd_t q_cmd,
  output logic               q_pop,
  // Result channel.
  output logic               out_valid,
  input  wire logic          out_ready,
  output bra_pkg::res_t      out_res
);

  localparam int RW = bra_pkg::ROW_W;
  localparam int NW = bra_pkg::NODE_W;
  localparam int IW = bra_pkg::IDX_W;
  localparam int SD = bra_pkg::STORE_DEPTH;

  bra_pkg::eng_state_t state_r, state_nxt;

  logic [RW-1:0] rel_r  [SD];
  logic [RW-1:0] clos_r [SD];
  logic [NW-1:0] nodes_r;
  logic [IW-1:0] cnt_r;
  logic          refl_r, irrefl_r, trans_r, symm_r, anti_r;
  logic          out_valid_r;
  bra_pkg::res_t out_r;

  logic          do_pop, do_prep, do_step, do_emit;
  logic          out_free;
  logic          cnt_last;
  logic [RW-1:0] mask;
  logic [RW-1:0] row_c, inv_c, sq_c, diag_c;

  assign out_free = !out_valid_r || out_ready;
  assign cnt_last = ({1'b0, cnt_r} == (nodes_r - NW'(1)));

  // Column mask for the active element count.
  always_comb begin
    for (int j = 0; j < RW; j++) begin
      mask[j] = (NW'(j) < nodes_r);
    end
  end

  // Row, column and Boolean square of the current row.
  always_comb begin
    row_c  = rel_r[cnt_r];
    diag_c = RW'(1) << cnt_r;
    sq_c   = '0;
    for (int j = 0; j < SD; j++) begin
      inv_c[j] = rel_r[j][cnt_r];
      if (row_c[j]) begin
        sq_c = sq_c | rel_r[j];
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bra_pkg::ST_LOAD: begin
        if (do_pop && q_cmd.last_row) state_nxt = bra_pkg::ST_PREP;
      end
      bra_pkg::ST_PREP: begin
        state_nxt = bra_pkg::ST_CLOSE;
      end
      bra_pkg::ST_CLOSE: begin
        if (cnt_last) state_nxt = bra_pkg::ST_EMIT;
      end
      bra_pkg::ST_EMIT: begin
        if (do_emit && cnt_last) state_nxt = bra_pkg::ST_LOAD;
      end
      default: begin
        state_nxt = bra_pkg::ST_LOAD;
      end
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    do_pop  = 1'b0;
    do_prep = 1'b0;
    do_step = 1'b0;
    do_emit = 1'b0;
    case (state_r)
      bra_pkg::ST_LOAD:  do_pop  = !q_empty;
      bra_pkg::ST_PREP:  do_prep = 1'b1;
      bra_pkg::ST_CLOSE: do_step = 1'b1;
      bra_pkg::ST_EMIT:  do_emit = out_free;
      default: begin
        do_pop = 1'b0;
      end
    endcase
  end

  assign q_pop = do_pop;

  // Matrix stores, flags and row counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bra_pkg::ST_LOAD;
      cnt_r       <= '0;
      nodes_r     <= bra_pkg::NODE_COUNT_RESET;
      out_valid_r <= 1'b0;
      refl_r      <= 1'b1;
      irrefl_r    <= 1'b1;
      trans_r     <= 1'b1;
      symm_r      <= 1'b1;
      anti_r      <= 1'b1;
      for (int i = 0; i < SD; i++) begin
        rel_r[i]  <= '0;
        clos_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;

      // Load a row; the final row also fixes the element count.
      if (do_pop) begin
        rel_r[q_cmd.row_index] <= q_cmd.row_bits;
        if (q_cmd.last_row) begin
          nodes_r <= q_cmd.nodes;
        end
      end

      // Trim the matrix to the active size and seed the closure.
      if (do_prep) begin
        for (int i = 0; i < SD; i++) begin
          if (NW'(i) < nodes_r) begin
            rel_r[i]  <= rel_r[i] & mask;
            clos_r[i] <= rel_r[i] & mask;
          end else begin
            rel_r[i]  <= '0;
            clos_r[i] <= '0;
          end
        end
        refl_r   <= 1'b1;
        irrefl_r <= 1'b1;
        trans_r  <= 1'b1;
        symm_r   <= 1'b1;
        anti_r   <= 1'b1;
        cnt_r    <= '0;
      end

      // One Warshall pivot over all rows, plus property checks on one row.
      if (do_step) begin
        for (int i = 0; i < SD; i++) begin
          if (clos_r[i][cnt_r]) begin
            clos_r[i] <= clos_r[i] | clos_r[cnt_r];
          end
        end
        if (row_c[cnt_r]) irrefl_r <= 1'b0;
        else              refl_r   <= 1'b0;
        if ((sq_c & ~row_c) != '0)                trans_r <= 1'b0;
        if (row_c != inv_c)                       symm_r  <= 1'b0;
        if ((row_c & inv_c & ~diag_c) != '0)      anti_r  <= 1'b0;
        cnt_r <= cnt_last ? '0 : cnt_r + IW'(1);
      end

      // Emit one row; the store is cleared after the final row.
      if (do_emit) begin
        cnt_r <= cnt_last ? '0 : cnt_r + IW'(1);
        if (cnt_last) begin
          for (int i = 0; i < SD; i++) begin
            rel_r[i]  <= '0;
            clos_r[i] <= '0;
          end
        end
      end

      // Output register handshake.
      if (do_emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (do_emit) begin
      out_r.out_row          <= cnt_r;
      out_r.closure_row      <= clos_r[cnt_r];
      out_r.reflexive_row    <= (row_c | diag_c) & mask;
      out_r.symmetric_row    <= row_c | inv_c;
      out_r.inverse_row      <= inv_c;
      out_r.square_row       <= sq_c;
      out_r.is_reflexive     <= refl_r;
      out_r.is_irreflexive   <= irrefl_r;
      out_r.is_transitive    <= trans_r;
      out_r.is_symmetric     <= symm_r;
      out_r.is_antisymmetric <= anti_r;
      out_r.last_result      <= cnt_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule
`default_nettype wire

### hdl/binary_relation_analyzer.sv
`default_nettype none
// Boolean relation analyzer. Rows of an N by N relation (N = node_count, clamped to
// 1..min(MAX_NODES,16)) are loaded one item each, held off while the queue is full.
// The item flagged last_row starts the run: a prep step trims the matrix, then N
// pivot steps compute the transitive closure one Warshall pivot per cycle across
// all rows in parallel, while the same pass checks one row per cycle for the five
// properties. N results follow, one per cycle while out_ready allows, through a
// single output register. A four-entry queue lets the input side keep accepting
// items while a run is in progress, until it fills. The matrix store is cleared
// after the final result of each run.
module binary_relation_analyzer #(
  parameter int MAX_NODES = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // Configuration port.
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [bra_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [bra_pkg::PDATA_W-1:0]  pwdata,
  output logic      [bra_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready,
  // Input channel.
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [bra_pkg::IDX_W-1:0]    in_row_index,
  input  wire logic [bra_pkg::ROW_W-1:0]    in_row_bits,
  input  wire logic                         in_last_row,
  // Result channel.
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [bra_pkg::IDX_W-1:0]    out_row,
  output logic      [bra_pkg::ROW_W-1:0]    out_closure_row,
  output logic      [bra_pkg::ROW_W-1:0]    out_reflexive_row,
  output logic      [bra_pkg::ROW_W-1:0]    out_symmetric_row,
  output logic      [bra_pkg::ROW_W-1:0]    out_inverse_row,
  output logic      [bra_pkg::ROW_W-1:0]    out_square_row,
  output logic                              out_is_reflexive,
  output logic                              out_is_irreflexive,
  output logic                              out_is_transitive,
  output logic                              out_is_symmetric,
  output logic                              out_is_antisymmetric,
  output logic                              out_last_result
);

  logic          q_full, q_push, q_empty, q_pop;
  bra_pkg::cmd_t push_cmd, pop_cmd;
  bra_pkg::res_t res;

  // Front: configuration and item classification.
  bra_front #(
    .MAX_NODES (MAX_NODES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_row_index (in_row_index),
    .in_row_bits  (in_row_bits),
    .in_last_row  (in_last_row),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (push_cmd)
  );

  // Queue between front and back.
  bra_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  // Back: matrix store, closure and emission.
  bra_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_cmd     (pop_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_row              = res.out_row;
  assign out_closure_row      = res.closure_row;
  assign out_reflexive_row    = res.reflexive_row;
  assign out_symmetric_row    = res.symmetric_row;
  assign out_inverse_row      = res.inverse_row;
  assign out_square_row       = res.square_row;
  assign out_is_reflexive     = res.is_reflexive;
  assign out_is_irreflexive   = res.is_irreflexive;
  assign out_is_transitive    = res.is_transitive;
  assign out_is_symmetric     = res.is_symmetric;
  assign out_is_antisymmetric = res.is_antisymmetric;
  assign out_last_result      = res.last_result;

endmodule
`default_nettype wire

### hdl/bra_checker.sv
`default_nettype none
module bra_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic [bra_pkg::IDX_W-1:0] in_row_index,
  input wire logic [bra_pkg::ROW_W-1:0] in_row_bits,
  input wire logic                      in_last_row,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [bra_pkg::IDX_W-1:0] out_row,
  input wire logic [bra_pkg::ROW_W-1:0] out_closure_row,
  input wire logic [bra_pkg::ROW_W-1:0] out_symmetric_row,
  input wire logic [bra_pkg::ROW_W-1:0] out_inverse_row,
  input wire logic [bra_pkg::ROW_W-1:0] out_square_row,
  input wire logic                      out_is_reflexive,
  input wire logic                      out_is_irreflexive,
  input wire logic                      out_is_symmetric,
  input wire logic                      out_last_result
);

  // A stalled input item holds.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_row_index) &&
      $stable(in_row_bits) && $stable(in_last_row))
    else $error("input item changed while stalled");

  // A stalled result item holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row) &&
      $stable(out_closure_row) && $stable(out_last_result))
    else $error("result item changed while stalled");

  // A nonempty set cannot be both reflexive and irreflexive.
  a_refl_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_reflexive && out_is_irreflexive))
    else $error("reflexive and irreflexive both set");

  // Every two-step path is in the transitive closure.
  a_square_in_closure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_square_row & ~out_closure_row) == '0))
    else $error("square row not contained in closure row");

  // For a symmetric relation the symmetric closure equals the transpose.
  a_symm_rows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_symmetric |-> (out_symmetric_row == out_inverse_row))
    else $error("symmetric relation with differing closure and transpose");

endmodule

bind binary_relation_analyzer bra_checker u_bra_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .in_row_index      (in_row_index),
  .in_row_bits       (in_row_bits),
  .in_last_row       (in_last_row),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_row           (out_row),
  .out_closure_row   (out_closure_row),
  .out_symmetric_row (out_symmetric_row),
  .out_inverse_row   (out_inverse_row),
  .out_square_row    (out_square_row),
  .out_is_reflexive  (out_is_reflexive),
  .out_is_irreflexive(out_is_irreflexive),
  .out_is_symmetric  (out_is_symmetric),
  .out_last_result   (out_last_result)
);
`default_nettype wire
